/* hw/rtl/sbbc_pkg.sv */
// Shared types, widths and codes for the swept box-box collision block.
package sbbc_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int TIME_W = 31;
	localparam int DIST_W = 34;
	localparam int DIV_W = 64;
	localparam int SPEED_W = 32;
	localparam int PIPE_LEN = TIME_W + 1;
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = 2;
	localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

	localparam logic [2:0] NC_NONE = 3'd0;
	localparam logic [2:0] NC_MINUS_X = 3'd1;
	localparam logic [2:0] NC_PLUS_X = 3'd2;
	localparam logic [2:0] NC_MINUS_Y = 3'd3;
	localparam logic [2:0] NC_PLUS_Y = 3'd4;

	typedef struct packed {
		logic signed [31:0] still_x;
		logic signed [31:0] still_y;
		logic [30:0] still_width;
		logic [30:0] still_height;
		logic signed [31:0] moving_x;
		logic signed [31:0] moving_y;
		logic [30:0] moving_width;
		logic [30:0] moving_height;
		logic signed [31:0] move_dx;
		logic signed [31:0] move_dy;
	} in_t;

	typedef struct packed {
		logic hit;
		logic [30:0] first_time;
		logic [30:0] last_time;
		logic [2:0] normal_code;
	} out_t;

	// Per-axis case outcome, all that the back end needs besides the quotients
	typedef struct packed {
		logic rej;
		logic has_entry;
		logic [2:0] code;
	} side_t;

	typedef struct packed {
		side_t side;
		logic [DIST_W-1:0] ent_dist;
		logic [DIST_W-1:0] ext_dist;
		logic [SPEED_W-1:0] mag;
	} axis_t;

	typedef struct packed {
		axis_t ax;
		axis_t ay;
	} work_t;

endpackage

/* hw/rtl/sbbc_front.sv */
// Front end: edge arithmetic and left/right/overlap classification per axis.
module sbbc_front (
	input sbbc_pkg::in_t in_data,
	output sbbc_pkg::work_t work
);
	import sbbc_pkg::*;

	function automatic axis_t classify(
		input logic signed [31:0] min0, input logic [30:0] sz0,
		input logic signed [31:0] min1, input logic [30:0] sz1,
		input logic signed [31:0] spd, input logic [2:0] minus_c,
		input logic [2:0] plus_c);
		logic signed [33:0] lo0, hi0, lo1, hi1;
		logic signed [34:0] d_ent, d_ext;
		logic [32:0] neg;
		axis_t a;
		lo0 = 34'(min0);
		lo1 = 34'(min1);
		hi0 = lo0 + $signed({3'b000, sz0});
		hi1 = lo1 + $signed({3'b000, sz1});
		a.side.has_entry = 1'b0;
		a.side.code = NC_NONE;
		a.side.rej = 1'b0;
		d_ent = '0;
		if (hi1 < lo0) begin
			a.side.rej = (spd <= 0);
			a.side.has_entry = 1'b1;
			a.side.code = minus_c;
			d_ent = 35'(lo0) - 35'(hi1);
			d_ext = 35'(hi0) - 35'(lo1);
		end else if (hi0 < lo1) begin
			a.side.rej = (spd >= 0);
			a.side.has_entry = 1'b1;
			a.side.code = plus_c;
			d_ent = 35'(lo1) - 35'(hi0);
			d_ext = 35'(hi1) - 35'(lo0);
		end else if (spd >= 0) begin
			d_ext = 35'(hi0) - 35'(lo1);
		end else begin
			d_ext = 35'(hi1) - 35'(lo0);
		end
		neg = -{spd[31], spd};
		a.mag = spd[31] ? neg[31:0] : spd;
		a.ent_dist = d_ent[34] ? '0 : d_ent[DIST_W-1:0];
		a.ext_dist = d_ext[34] ? '0 : d_ext[DIST_W-1:0];
		return a;
	endfunction

	// Classify both axes side by side
	assign work.ax = classify(in_data.still_x, in_data.still_width, in_data.moving_x,
		in_data.moving_width, in_data.move_dx, NC_MINUS_X, NC_PLUS_X);
	assign work.ay = classify(in_data.still_y, in_data.still_height, in_data.moving_y,
		in_data.moving_height, in_data.move_dy, NC_MINUS_Y, NC_PLUS_Y);

endmodule

/* hw/rtl/sbbc_fifo.sv */
// Short queue between the front end and the divider back end.
module sbbc_fifo (
	input logic clk,
	input logic arst_n,
	input logic push,
	input sbbc_pkg::work_t wdata,
	input logic pop,
	output logic full,
	output logic nonempty,
	output sbbc_pkg::work_t rdata
);
	import sbbc_pkg::*;

	work_t mem_q [0:FIFO_DEPTH-1];
	logic [FIFO_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [FIFO_PTR_W:0] count_q;

	assign full = (count_q == (FIFO_PTR_W+1)'(FIFO_DEPTH));
	assign nonempty = (count_q != '0);
	assign rdata = mem_q[rd_ptr_q];

	// Store the incoming beat
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	// Advance pointers and track fill
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* hw/rtl/sbbc_div.sv */
// Pipelined restoring divider: (span << FRAC_BITS) / mag, saturated, one bit per stage.
module sbbc_div #(
	parameter int FRAC_BITS = sbbc_pkg::FRAC_BITS_DEF
) (
	input logic clk,
	input logic en,
	input logic [sbbc_pkg::DIST_W-1:0] span,
	input logic [sbbc_pkg::SPEED_W-1:0] mag,
	output logic [sbbc_pkg::TIME_W-1:0] quo
);
	import sbbc_pkg::*;

	logic [DIV_W-1:0] rem_s [0:TIME_W];
	logic [SPEED_W-1:0] den_s [0:TIME_W];
	logic [TIME_W-1:0] quo_s [0:TIME_W];
	logic sat_s [0:TIME_W];
	logic [DIV_W-1:0] num;

	assign num = DIV_W'(span) << FRAC_BITS;

	// Load numerator; flag zero speed or a quotient past the time range
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= num;
			den_s[0] <= mag;
			quo_s[0] <= '0;
			sat_s[0] <= (mag == '0) || (num >= (DIV_W'(mag) << TIME_W));
		end
	end

	// One quotient bit per stage, MSB first
	for (genvar k = 1; k <= TIME_W; k++) begin : g_stage
		localparam int B = TIME_W - k;
		logic [DIV_W-1:0] shd;
		logic take;
		assign shd = DIV_W'(den_s[k-1]) << B;
		assign take = (rem_s[k-1] >= shd);
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= take ? rem_s[k-1] - shd : rem_s[k-1];
				den_s[k] <= den_s[k-1];
				quo_s[k] <= quo_s[k-1];
				quo_s[k][B] <= take;
				sat_s[k] <= sat_s[k-1];
			end
		end
	end

	assign quo = sat_s[TIME_W] ? TIME_MAX : quo_s[TIME_W];

endmodule

/* hw/rtl/sbbc_back.sv */
// Back end: four dividers, case flags carried alongside, interval merge into the output register.
module sbbc_back #(
	parameter int FRAC_BITS = sbbc_pkg::FRAC_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic work_valid,
	input sbbc_pkg::work_t work,
	output logic pop,
	output logic out_valid,
	input logic out_stall,
	output sbbc_pkg::out_t out_data
);
	import sbbc_pkg::*;

	logic en;
	logic v_s [0:PIPE_LEN-1];
	side_t sx_s [0:PIPE_LEN-1];
	side_t sy_s [0:PIPE_LEN-1];
	logic [TIME_W-1:0] tex, txx, tey, txy;
	logic [TIME_W-1:0] tfx, tf, tl;
	logic [2:0] ncx, nc;
	logic okx, ok;
	logic out_valid_q;
	out_t out_q;

	// Whole pipe moves unless the output beat is held
	assign en = !out_valid_q || !out_stall;
	assign pop = en && work_valid;

	sbbc_div #(.FRAC_BITS(FRAC_BITS)) u_div_ex (.clk(clk), .en(en),
		.span(work.ax.ent_dist), .mag(work.ax.mag), .quo(tex));
	sbbc_div #(.FRAC_BITS(FRAC_BITS)) u_div_xx (.clk(clk), .en(en),
		.span(work.ax.ext_dist), .mag(work.ax.mag), .quo(txx));
	sbbc_div #(.FRAC_BITS(FRAC_BITS)) u_div_ey (.clk(clk), .en(en),
		.span(work.ay.ent_dist), .mag(work.ay.mag), .quo(tey));
	sbbc_div #(.FRAC_BITS(FRAC_BITS)) u_div_xy (.clk(clk), .en(en),
		.span(work.ay.ext_dist), .mag(work.ay.mag), .quo(txy));

	// Carry case flags in step with the dividers
	always_ff @(posedge clk) begin
		if (en) begin
			sx_s[0] <= work.ax.side;
			sy_s[0] <= work.ay.side;
			for (int k = 1; k < PIPE_LEN; k++) begin
				sx_s[k] <= sx_s[k-1];
				sy_s[k] <= sy_s[k-1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < PIPE_LEN; k++) begin
				v_s[k] <= 1'b0;
			end
		end else if (en) begin
			v_s[0] <= work_valid;
			for (int k = 1; k < PIPE_LEN; k++) begin
				v_s[k] <= v_s[k-1];
			end
		end
	end

	// Narrow the contact interval: x axis, then y axis
	always_comb begin
		tfx = '0;
		ncx = NC_NONE;
		if (sx_s[PIPE_LEN-1].has_entry && tex != '0) begin
			tfx = tex;
			ncx = sx_s[PIPE_LEN-1].code;
		end
		okx = !sx_s[PIPE_LEN-1].rej && (tfx <= txx);
		tf = tfx;
		nc = ncx;
		if (sy_s[PIPE_LEN-1].has_entry && tey > tfx) begin
			tf = tey;
			nc = sy_s[PIPE_LEN-1].code;
		end
		tl = (txy < txx) ? txy : txx;
		ok = okx && !sy_s[PIPE_LEN-1].rej && (tf <= tl);
	end

	// Register the result beat
	always_ff @(posedge clk) begin
		if (en) begin
			if (ok) begin
				out_q.hit <= ({1'b0, tf} <= (TIME_W+1)'(64'd1 << FRAC_BITS));
				out_q.first_time <= tf;
				out_q.last_time <= tl;
				out_q.normal_code <= nc;
			end else begin
				out_q <= '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= v_s[PIPE_LEN-1];
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

endmodule

/* hw/rtl/swept_box_box_collision_top.sv */
// Top level of the swept box-box collision block.
//
// Input channel: in_valid / in_stall / in_data carry one box pair and its
// displacement per beat. Output channel: out_valid / out_stall / out_data
// carry hit, first and last contact time and the contact normal.
// A beat moves when valid is high and stall is low.
//
// Throughput: one pair per cycle while out_stall is low. An input beat passes
// the queue register, 32 divider stages (the load stage and one quotient
// bit per stage over 31 time bits) and the output register on its way
// to its output beat.
//
// A four-entry queue separates the classifying front end from the divider
// pipe. When out_stall holds back a waiting output beat the whole divider
// pipe holds; the queue then fills and in_stall rises once it is full.
// Reset clears the queue, all stage valid bits and out_valid; items in
// flight are dropped, and none is kept across reset.
module swept_box_box_collision_top #(
	parameter int FRAC_BITS = sbbc_pkg::FRAC_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input sbbc_pkg::in_t in_data,
	output logic out_valid,
	input logic out_stall,
	output sbbc_pkg::out_t out_data
);
	import sbbc_pkg::*;

	work_t work_in, work_out;
	logic full, nonempty, pop, push;

	assign in_stall = full;
	assign push = in_valid && !full;

	sbbc_front u_front (.in_data(in_data), .work(work_in));

	sbbc_fifo u_fifo (.clk(clk), .arst_n(arst_n), .push(push), .wdata(work_in),
		.pop(pop), .full(full), .nonempty(nonempty), .rdata(work_out));

	sbbc_back #(.FRAC_BITS(FRAC_BITS)) u_back (.clk(clk), .arst_n(arst_n),
		.work_valid(nonempty), .work(work_out), .pop(pop), .out_valid(out_valid),
		.out_stall(out_stall), .out_data(out_data));

endmodule

/* hw/rtl/sbbc_chk.sv */
// Port-level checker for the collision block, bound to the top level.
module sbbc_chk (
	input logic clk,
	input logic arst_n,
	input logic out_valid,
	input logic out_stall,
	input sbbc_pkg::out_t out_data
);
	import sbbc_pkg::*;

	// Held beat stays offered
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("output beat dropped while stalled");

	// Held beat keeps its payload
	a_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(out_data))
		else $error("output payload changed while stalled");

	// A hit has a valid contact interval
	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.hit |-> out_data.first_time <= out_data.last_time)
		else $error("hit with first time past last time");

	// Normal code stays in its range
	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.normal_code <= NC_PLUS_Y)
		else $error("normal code out of range");

	// A normal means an entry time above zero
	a_entry: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.normal_code != NC_NONE |-> out_data.first_time != '0)
		else $error("normal set with zero first time");

endmodule

bind swept_box_box_collision_top sbbc_chk u_chk (.clk(clk), .arst_n(arst_n),
	.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data));

/* dv/swept_box_box_collision_top_test.sv */
// Testbench for the swept box-box collision block: directed table, random pairs, predictor.
module swept_box_box_collision_top_test;
	import sbbc_pkg::*;

	localparam int FB = 16;
	localparam longint TMAX = 64'h7FFFFFFF;
	localparam int LATENCY = 34;
	localparam int CYCLE_LIMIT = 400000;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	in_t in_data;
	logic out_valid;
	logic out_stall;
	out_t out_data;

	swept_box_box_collision_top #(.FRAC_BITS(FB)) u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);

	// Directed row: pair plus an optional typed-in result
	typedef struct {
		in_t pair;
		bit has_exp;
		out_t exp;
	} row_t;

	out_t contact_q[$];
	int errors = 0;
	int cycles = 0;
	bit quiet_tail = 0;
	bit hold_long = 0;
	bit feeding_done = 0;

	initial clk = 0;
	always #5 clk = ~clk;

	// Entry/exit time: (span << FB) / speed, saturated
	function automatic longint contact_time(longint span, longint mag);
		longint q;
		if (mag <= 0)
			return TMAX;
		if (span < 0)
			span = 0;
		q = (span <<< FB) / mag;
		return (q > TMAX) ? TMAX : q;
	endfunction

	// Narrow the contact interval along one axis
	function automatic bit sweep_axis(longint min0, longint max0, longint min1, longint max1,
			longint speed, logic [2:0] minus_nc, logic [2:0] plus_nc,
			inout longint tf, inout longint tl, inout logic [2:0] nc);
		longint t;
		if (max1 < min0) begin
			if (speed <= 0)
				return 0;
			t = contact_time(min0 - max1, speed);
			if (t > tf) begin
				tf = t;
				nc = minus_nc;
			end
			t = contact_time(max0 - min1, speed);
			if (t < tl)
				tl = t;
		end else if (max0 < min1) begin
			if (speed >= 0)
				return 0;
			t = contact_time(min1 - max0, -speed);
			if (t > tf) begin
				tf = t;
				nc = plus_nc;
			end
			t = contact_time(max1 - min0, -speed);
			if (t < tl)
				tl = t;
		end else begin
			if (speed >= 0)
				t = contact_time(max0 - min1, speed);
			else
				t = contact_time(max1 - min0, -speed);
			if (t < tl)
				tl = t;
		end
		return tf <= tl;
	endfunction

	function automatic out_t predict_contact(in_t p);
		longint tf, tl;
		logic [2:0] nc;
		bit ok;
		out_t r;
		tf = 0;
		tl = TMAX;
		nc = NC_NONE;
		ok = sweep_axis(longint'(p.still_x), longint'(p.still_x) + longint'(p.still_width),
			longint'(p.moving_x), longint'(p.moving_x) + longint'(p.moving_width),
			longint'(p.move_dx), NC_MINUS_X, NC_PLUS_X, tf, tl, nc);
		if (ok)
			ok = sweep_axis(longint'(p.still_y), longint'(p.still_y) + longint'(p.still_height),
				longint'(p.moving_y), longint'(p.moving_y) + longint'(p.moving_height),
				longint'(p.move_dy), NC_MINUS_Y, NC_PLUS_Y, tf, tl, nc);
		r = '0;
		if (ok) begin
			r.hit = (tf <= (longint'(1) << FB));
			r.first_time = tf[30:0];
			r.last_time = tl[30:0];
			r.normal_code = nc;
		end
		return r;
	endfunction

	function automatic in_t mk_pair(int sx, int sy, int sw, int sh, int mx, int my,
			int mw, int mh, int dx, int dy);
		in_t p;
		p.still_x = sx; p.still_y = sy; p.still_width = sw[30:0]; p.still_height = sh[30:0];
		p.moving_x = mx; p.moving_y = my; p.moving_width = mw[30:0];
		p.moving_height = mh[30:0]; p.move_dx = dx; p.move_dy = dy;
		return p;
	endfunction

	// Random pair: mostly nearby boxes with modest moves, some full-range noise
	function automatic in_t rand_pair();
		in_t p;
		int sel;
		sel = $urandom_range(0, 9);
		if (sel < 2) begin
			p = $bits(in_t)'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
				$urandom, $urandom, $urandom, $urandom});
		end else begin
			p.still_x = $signed($urandom_range(0, 32'h000FFFFF)) - 32'sh00080000;
			p.still_y = $signed($urandom_range(0, 32'h000FFFFF)) - 32'sh00080000;
			p.still_width = 31'($urandom_range(0, 32'h0003FFFF));
			p.still_height = 31'($urandom_range(0, 32'h0003FFFF));
			p.moving_x = $signed($urandom_range(0, 32'h000FFFFF)) - 32'sh00080000;
			p.moving_y = $signed($urandom_range(0, 32'h000FFFFF)) - 32'sh00080000;
			p.moving_width = 31'($urandom_range(0, 32'h0003FFFF));
			p.moving_height = 31'($urandom_range(0, 32'h0003FFFF));
			if (sel < 8) begin
				// aim the move at the still box
				p.move_dx = (p.still_x - p.moving_x) + ($signed($urandom_range(0, 32'h3FFFF))
					- 32'sh1FFFF);
				p.move_dy = (p.still_y - p.moving_y) + ($signed($urandom_range(0, 32'h3FFFF))
					- 32'sh1FFFF);
			end else begin
				p.move_dx = $urandom;
				p.move_dy = $urandom;
			end
		end
		return p;
	endfunction

	row_t dir_rows[$];

	task automatic add_row(in_t p, bit has_exp, out_t e);
		row_t r;
		r.pair = p;
		r.has_exp = has_exp;
		r.exp = e;
		dir_rows.push_back(r);
	endtask

	task automatic send_pair(in_t p);
		int gap;
		if (!quiet_tail && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			for (gap = $urandom_range(1, 8); gap > 0; gap--)
				@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= p;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Stimulus
	initial begin
		int i;
		in_t p;
		out_t z;
		in_valid = 1'b0;
		in_data = '0;
		arst_n = 1'b0;
		z = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// rejections: typed-in zero result
		add_row(mk_pair(0, 0, 32'h10000, 32'h10000, -32'h30000, 0, 32'h10000, 32'h10000,
			0, 0), 1, z);
		add_row(mk_pair(0, 0, 32'h10000, 32'h10000, 32'h30000, 0, 32'h10000, 32'h10000,
			32'h10000, 0), 1, z);
		add_row(mk_pair(0, 0, 32'h10000, 32'h10000, 0, -32'h30000, 32'h10000, 32'h10000,
			0, -32'h10000), 1, z);
		// overlap at rest: hit, times 0 and infinity, no normal
		z.hit = 1; z.first_time = 0; z.last_time = TIME_MAX; z.normal_code = NC_NONE;
		add_row(mk_pair(0, 0, 32'h20000, 32'h20000, 32'h8000, 32'h8000, 32'h10000, 32'h10000,
			0, 0), 1, z);
		// left, right, above, below approaches
		add_row(mk_pair(0, 0, 32'h10000, 32'h10000, -32'h20000, 0, 32'h10000, 32'h10000,
			32'h20000, 0), 0, z);
		add_row(mk_pair(0, 0, 32'h10000, 32'h10000, 32'h30000, 0, 32'h10000, 32'h10000,
			-32'h40000, 0), 0, z);
		add_row(mk_pair(0, 0, 32'h10000, 32'h10000, 0, -32'h20000, 32'h10000, 32'h10000,
			0, 32'h20000), 0, z);
		add_row(mk_pair(0, 0, 32'h10000, 32'h10000, 0, 32'h30000, 32'h10000, 32'h10000,
			0, -32'h40000), 0, z);
		// late contact, interval failure, truncated entry time
		add_row(mk_pair(0, 0, 32'h10000, 32'h10000, -32'h50000, 0, 32'h10000, 32'h10000,
			32'h10000, 0), 0, z);
		add_row(mk_pair(0, 0, 32'h10000, 32'h10000, -32'h20000, -32'h90000, 32'h10000,
			32'h10000, 32'h10000, 32'h10000), 0, z);
		add_row(mk_pair(0, 0, 32'h10000, 32'h10000, -32'h10001, 0, 32'h10000, 32'h10000,
			32'h7FFFFFFF, 0), 0, z);
		// field extremes
		add_row(mk_pair(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000,
			32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF), 0, z);
		add_row(mk_pair(32'h80000000, 32'h80000000, 0, 0, 32'h7FFFFFFF, 32'h7FFFFFFF, 0, 0,
			32'h80000000, 32'h80000000), 0, z);
		add_row(mk_pair(32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
			32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h80000000), 0, z);
		add_row(mk_pair(-1, -1, 0, 0, -1, -1, 0, 0, -1, -1), 0, z);
		add_row('1, 0, z);
		add_row('0, 0, z);

		foreach (dir_rows[k]) begin
			contact_q.push_back(dir_rows[k].has_exp ? dir_rows[k].exp
				: predict_contact(dir_rows[k].pair));
			send_pair(dir_rows[k].pair);
		end

		for (i = 0; i < 750; i++) begin
			if (i == 200)
				hold_long = 1;
			if (i == 600)
				quiet_tail = 1;
			p = rand_pair();
			contact_q.push_back(predict_contact(p));
			send_pair(p);
		end
		in_valid <= 1'b0;
		feeding_done = 1;
	end

	// Receiver: random stall bursts, one long hold-off
	initial begin
		int n;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_long) begin
				hold_long = 0;
				out_stall <= 1'b1;
				for (n = 0; n < 200; n++)
					@(negedge clk);
				out_stall <= 1'b0;
			end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
				out_stall <= 1'b1;
				for (n = $urandom_range(1, 8); n > 0; n--)
					@(negedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// Compare each result beat against the oldest prediction
	always @(posedge clk) begin
		out_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (contact_q.size() == 0) begin
				$error("unexpected result beat");
				errors++;
			end else begin
				e = contact_q.pop_front();
				if (out_data.hit !== e.hit) begin
					$error("hit expected %0d actual %0d", e.hit, out_data.hit);
					errors++;
				end
				if (out_data.first_time !== e.first_time) begin
					$error("first_time expected %0h actual %0h", e.first_time,
						out_data.first_time);
					errors++;
				end
				if (out_data.last_time !== e.last_time) begin
					$error("last_time expected %0h actual %0h", e.last_time,
						out_data.last_time);
					errors++;
				end
				if (out_data.normal_code !== e.normal_code) begin
					$error("normal_code expected %0d actual %0d", e.normal_code,
						out_data.normal_code);
					errors++;
				end
			end
		end
	end

	// Finish after drain, or on timeout
	initial begin
		wait (feeding_done);
		while (contact_q.size() != 0)
			@(posedge clk);
		repeat (LATENCY * 2) @(posedge clk);
		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

endmodule

/* swept_box_box_collision_top.f */
hw/rtl/sbbc_pkg.sv
hw/rtl/sbbc_front.sv
hw/rtl/sbbc_fifo.sv
hw/rtl/sbbc_div.sv
hw/rtl/sbbc_back.sv
hw/rtl/swept_box_box_collision_top.sv
hw/rtl/sbbc_chk.sv
dv/swept_box_box_collision_top_test.sv
